### hdl/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg: shared types and constants of the swept box collision time unit
// Field widths, register indexes, axis and surface codes, lane status types.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int SIZE_W        = 31;
  localparam int EPS_W         = 16;
  localparam int TIME_W        = 17;
  localparam int IDX_W         = 2;
  localparam int DATA_W        = 32;
  // doubled-unit slab numerators
  localparam int NUM_W         = 36;
  // magnitude of twice the movement
  localparam int DIV_W         = 33;
  // doubled-unit overlap at contact
  localparam int OV_W          = 37;
  localparam int SQ_W          = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;
  localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd66;

  typedef enum logic [IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_EPS    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    SURF_FLOOR   = 2'd0,
    SURF_CEILING = 2'd1,
    SURF_WALL    = 2'd2
  } surface_t;

  // per-axis slab status
  typedef struct packed {
    logic nz;   // movement near zero on this axis
    logic sep;  // boxes apart on this axis at start
  } lane_stat_t;

  // sign handling around the unsigned divider
  typedef struct packed {
    logic sat;   // quotient at or above one
    logic zero;  // numerator zero
    logic neg;   // quotient negative
  } div_flag_t;

endpackage

### hdl/sbct_if.sv
// ----------------------------------------------------------------------------
// sbct_if: channel interfaces of the swept box collision time unit
// Test beat, result beat and configuration write channel.
// ----------------------------------------------------------------------------
interface sbct_in_if;
  logic valid;
  logic ready;
  logic signed [sbct_pkg::COORD_W-1:0] start_x, start_y, start_z;
  logic signed [sbct_pkg::COORD_W-1:0] move_x, move_y, move_z;
  logic signed [sbct_pkg::COORD_W-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [sbct_pkg::COORD_W-1:0] box_max_x, box_max_y, box_max_z;

  modport source (output valid, start_x, start_y, start_z, move_x, move_y, move_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, move_x, move_y, move_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface sbct_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [sbct_pkg::TIME_W-1:0] hit_time;
  logic [1:0] normal_axis;
  logic normal_negative;
  logic [1:0] surface_kind;
  logic signed [sbct_pkg::COORD_W-1:0] contact_x, contact_y, contact_z;

  modport source (output valid, hit, hit_time, normal_axis, normal_negative,
                  surface_kind, contact_x, contact_y, contact_z, input ready);
  modport sink (input valid, hit, hit_time, normal_axis, normal_negative,
                surface_kind, contact_x, contact_y, contact_z, output ready);
endinterface

interface sbct_cfg_if;
  logic valid;
  logic ready;
  logic [sbct_pkg::IDX_W-1:0] index;
  logic [sbct_pkg::DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/sbct_div_step.sv
// ----------------------------------------------------------------------------
// sbct_div_step: one registered step of a restoring divider
// Produces one quotient bit per stage; remainder stays below the divisor.
// ----------------------------------------------------------------------------
module sbct_div_step #(
  parameter int QUO_W = sbct_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sbct_pkg::DIV_W-1:0]   rem_in,
  input  logic [QUO_W-1:0]             quo_in,
  input  logic [sbct_pkg::DIV_W-1:0]   divisor,
  output logic [sbct_pkg::DIV_W-1:0]   rem_out,
  output logic [QUO_W-1:0]             quo_out
);

  logic [sbct_pkg::DIV_W:0] shifted;
  logic [sbct_pkg::DIV_W:0] diff;
  logic                     take;

  // trial subtract
  always_comb begin
    shifted = {rem_in, 1'b0};
    diff    = shifted - {1'b0, divisor};
    take    = shifted >= {1'b0, divisor};
  end

  // step register
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? diff[sbct_pkg::DIV_W-1:0] : shifted[sbct_pkg::DIV_W-1:0];
      quo_out <= {quo_in[QUO_W-2:0], take};
    end
  end

endmodule

### hdl/sbct_lane.sv
// ----------------------------------------------------------------------------
// sbct_lane: per-axis slab pipeline
// Slab numerators, two pipelined dividers, clamped entry/exit, contact centre
// and overlap at contact for one axis.
// ----------------------------------------------------------------------------
module sbct_lane #(
  parameter  int FRAC_BITS = sbct_pkg::FRAC_BITS_DEF,
  localparam int NST       = FRAC_BITS + 8,
  localparam int TW        = FRAC_BITS + 2
) (
  input  logic                                clk,
  input  logic [NST-1:0]                      step,
  input  logic signed [sbct_pkg::COORD_W-1:0] s,
  input  logic signed [sbct_pkg::COORD_W-1:0] m,
  input  logic signed [sbct_pkg::COORD_W-1:0] bmin,
  input  logic signed [sbct_pkg::COORD_W-1:0] bmax,
  input  logic [sbct_pkg::SIZE_W-1:0]         sz,
  input  logic [sbct_pkg::EPS_W-1:0]          eps,
  output logic [sbct_pkg::SQ_W-1:0]           msq,
  output logic                                mzero,
  output sbct_pkg::lane_stat_t                stat,
  output logic signed [TW-1:0]                slab_entry,
  output logic signed [TW-1:0]                slab_exit,
  input  logic [FRAC_BITS:0]                  t_hit,
  output logic signed [sbct_pkg::OV_W-1:0]    ov,
  output logic                                above,
  output logic signed [sbct_pkg::COORD_W-1:0] csat
);

  localparam int CW  = sbct_pkg::COORD_W + 1;
  localparam int PW  = sbct_pkg::COORD_W + FRAC_BITS + 2;
  localparam int NW  = sbct_pkg::NUM_W;
  localparam int DW  = sbct_pkg::DIV_W;
  localparam int OW  = sbct_pkg::OV_W;
  localparam int XW  = sbct_pkg::COORD_W;
  localparam logic signed [TW-1:0] T_ONE = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [XW-1:0] C_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] C_MIN = {1'b1, {(XW-1){1'b0}}};

  // pipeline carries
  logic signed [XW-1:0] s_p  [0:FRAC_BITS+4];
  logic signed [XW-1:0] m_p  [0:FRAC_BITS+3];
  logic signed [XW-1:0] bn_p [0:FRAC_BITS+5];
  logic signed [XW-1:0] bx_p [0:FRAC_BITS+5];
  sbct_pkg::lane_stat_t stat_p [0:FRAC_BITS+1];
  logic [DW-1:0]        d_p  [0:FRAC_BITS];
  sbct_pkg::div_flag_t  fl1_p [0:FRAC_BITS];
  sbct_pkg::div_flag_t  fl2_p [0:FRAC_BITS];
  logic [DW-1:0]        rem1 [0:FRAC_BITS];
  logic [DW-1:0]        rem2 [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] quo1 [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] quo2 [0:FRAC_BITS];

  logic signed [NW-1:0] s2, mn2, mx2, szw, lo, hi, num1_w, num2_w;
  logic signed [NW-1:0] num1_r, num2_r;
  logic [XW-1:0]        mu, am;
  logic signed [sbct_pkg::SQ_W-1:0] msq_w;
  logic [NW-1:0]        an1, an2;
  sbct_pkg::div_flag_t  f1, f2;
  logic signed [TW-1:0] t1, t2;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] c_r;
  logic signed [OW-1:0] c2, mn2o, mx2o, szo, mnx, ov_a, ov_b;

  function automatic logic signed [TW-1:0] clamp_t(sbct_pkg::div_flag_t f,
                                                    logic [FRAC_BITS-1:0] q);
    logic signed [TW-1:0] r;
    if (f.zero)     r = '0;
    else if (f.neg) r = '1;
    else if (f.sat) r = T_ONE;
    else            r = {2'b00, q};
    return r;
  endfunction

  // slab numerators, separation and near-zero test
  always_comb begin
    s2     = {{(NW-XW-1){s[XW-1]}}, s, 1'b0};
    mn2    = {{(NW-XW-1){bmin[XW-1]}}, bmin, 1'b0};
    mx2    = {{(NW-XW-1){bmax[XW-1]}}, bmax, 1'b0};
    szw    = {{(NW-sbct_pkg::SIZE_W){1'b0}}, sz};
    lo     = s2 - szw;
    hi     = s2 + szw;
    num1_w = mn2 - hi;
    num2_w = mx2 - lo;
    mu     = m;
    am     = mu[XW-1] ? (~mu + {{(XW-1){1'b0}}, 1'b1}) : mu;
    msq_w  = m * m;
  end

  always_ff @(posedge clk) begin
    if (step[0]) begin
      num1_r        <= num1_w;
      num2_r        <= num2_w;
      d_p[0]        <= {am, 1'b0};
      stat_p[0].sep <= (hi < mn2) || (lo > mx2);
      stat_p[0].nz  <= (mu == '0) || (am < {{(XW-sbct_pkg::EPS_W){1'b0}}, eps});
      msq           <= msq_w;
      mzero         <= (mu == '0);
      s_p[0]        <= s;
      m_p[0]        <= m;
      bn_p[0]       <= bmin;
      bx_p[0]       <= bmax;
    end
  end

  // operand carries
  for (genvar k = 1; k <= FRAC_BITS + 5; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (step[k]) begin
        bn_p[k] <= bn_p[k-1];
        bx_p[k] <= bx_p[k-1];
      end
    end
    if (k <= FRAC_BITS + 4) begin : g_s
      always_ff @(posedge clk) if (step[k]) s_p[k] <= s_p[k-1];
    end
    if (k <= FRAC_BITS + 3) begin : g_m
      always_ff @(posedge clk) if (step[k]) m_p[k] <= m_p[k-1];
    end
    if (k <= FRAC_BITS + 1) begin : g_st
      always_ff @(posedge clk) if (step[k]) stat_p[k] <= stat_p[k-1];
    end
    if (k <= FRAC_BITS) begin : g_d
      always_ff @(posedge clk) begin
        if (step[k]) d_p[k] <= d_p[k-1];
        if (step[k+1]) begin
          fl1_p[k] <= fl1_p[k-1];
          fl2_p[k] <= fl2_p[k-1];
        end
      end
    end
  end

  // divider setup: magnitudes, saturation and sign
  always_comb begin
    an1    = num1_r[NW-1] ? NW'(-num1_r) : NW'(num1_r);
    an2    = num2_r[NW-1] ? NW'(-num2_r) : NW'(num2_r);
    f1.sat  = an1 >= {{(NW-DW){1'b0}}, d_p[0]};
    f1.zero = (num1_r == '0);
    f1.neg  = num1_r[NW-1] ^ m_p[0][XW-1];
    f2.sat  = an2 >= {{(NW-DW){1'b0}}, d_p[0]};
    f2.zero = (num2_r == '0);
    f2.neg  = num2_r[NW-1] ^ m_p[0][XW-1];
  end

  always_ff @(posedge clk) begin
    if (step[1]) begin
      rem1[0]  <= an1[DW-1:0];
      rem2[0]  <= an2[DW-1:0];
      fl1_p[0] <= f1;
      fl2_p[0] <= f2;
    end
  end

  assign quo1[0] = '0;
  assign quo2[0] = '0;

  // one quotient bit per stage for both slab times
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    sbct_div_step #(.QUO_W(FRAC_BITS)) u_div1 (
      .clk(clk), .en(step[k+2]), .rem_in(rem1[k]), .quo_in(quo1[k]),
      .divisor(d_p[k+1]), .rem_out(rem1[k+1]), .quo_out(quo1[k+1])
    );
    sbct_div_step #(.QUO_W(FRAC_BITS)) u_div2 (
      .clk(clk), .en(step[k+2]), .rem_in(rem2[k]), .quo_in(quo2[k]),
      .divisor(d_p[k+1]), .rem_out(rem2[k+1]), .quo_out(quo2[k+1])
    );
  end

  // clamped slab times, ordered into entry and exit
  always_comb begin
    t1 = clamp_t(fl1_p[FRAC_BITS], quo1[FRAC_BITS]);
    t2 = clamp_t(fl2_p[FRAC_BITS], quo2[FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+2]) begin
      slab_entry <= (t1 < t2) ? t1 : t2;
      slab_exit  <= (t1 < t2) ? t2 : t1;
      stat       <= stat_p[FRAC_BITS+1];
    end
  end

  // movement scaled by contact time
  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+4]) prod <= m_p[FRAC_BITS+3] * $signed({1'b0, t_hit});
  end

  // contact centre
  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+5]) c_r <= CW'(s_p[FRAC_BITS+4]) + CW'(prod >>> FRAC_BITS);
  end

  // overlap at contact and side of the static centre
  always_comb begin
    c2   = {{(OW-CW-1){c_r[CW-1]}}, c_r, 1'b0};
    mn2o = {{(OW-XW-1){bn_p[FRAC_BITS+5][XW-1]}}, bn_p[FRAC_BITS+5], 1'b0};
    mx2o = {{(OW-XW-1){bx_p[FRAC_BITS+5][XW-1]}}, bx_p[FRAC_BITS+5], 1'b0};
    szo  = {{(OW-sbct_pkg::SIZE_W){1'b0}}, sz};
    mnx  = OW'(bn_p[FRAC_BITS+5]) + OW'(bx_p[FRAC_BITS+5]);
    ov_a = c2 + szo - mn2o;
    ov_b = mx2o - c2 + szo;
  end

  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+6]) begin
      ov    <= (ov_a < ov_b) ? ov_a : ov_b;
      above <= c2 > mnx;
      if (c_r[CW-1] != c_r[CW-2]) csat <= c_r[CW-1] ? C_MIN : C_MAX;
      else                        csat <= c_r[XW-1:0];
    end
  end

endmodule

### hdl/sbct_merge.sv
// ----------------------------------------------------------------------------
// sbct_merge: combines the three axis lanes
// Short-movement test, latest entry against earliest exit, contact time,
// normal axis selection and the result register.
// ----------------------------------------------------------------------------
module sbct_merge #(
  parameter  int FRAC_BITS = sbct_pkg::FRAC_BITS_DEF,
  localparam int NST       = FRAC_BITS + 8,
  localparam int TW        = FRAC_BITS + 2
) (
  input  logic                                clk,
  input  logic [NST-1:0]                      step,
  input  logic [sbct_pkg::EPS_W-1:0]          eps,
  input  logic [sbct_pkg::SQ_W-1:0]           msq [3],
  input  logic                                mzero [3],
  input  sbct_pkg::lane_stat_t                stat [3],
  input  logic signed [TW-1:0]                slab_entry [3],
  input  logic signed [TW-1:0]                slab_exit [3],
  output logic [FRAC_BITS:0]                  t_hit,
  input  logic signed [sbct_pkg::OV_W-1:0]    ov [3],
  input  logic                                above [3],
  input  logic signed [sbct_pkg::COORD_W-1:0] csat [3],
  output logic                                hit,
  output logic [sbct_pkg::TIME_W-1:0]         hit_time,
  output logic [1:0]                          normal_axis,
  output logic                                normal_negative,
  output logic [1:0]                          surface_kind,
  output logic signed [sbct_pkg::COORD_W-1:0] contact_x,
  output logic signed [sbct_pkg::COORD_W-1:0] contact_y,
  output logic signed [sbct_pkg::COORD_W-1:0] contact_z
);

  localparam logic signed [TW-1:0] T_ONE = {2'b01, {FRAC_BITS{1'b0}}};

  logic                 short_p [0:FRAC_BITS+1];
  logic                 hit_p   [0:3];
  logic [FRAC_BITS:0]   t_p     [0:3];
  logic [sbct_pkg::SQ_W-1:0] len2;
  logic [2*sbct_pkg::EPS_W-1:0] eps2;
  logic signed [TW-1:0] ent, ext;
  logic                 any_sep, sep_nz, hit_w;
  logic [FRAC_BITS:0]   t_w;
  sbct_pkg::axis_t      ax;
  logic                 neg_w;

  // short movement test
  always_comb begin
    len2 = msq[0] + msq[1] + msq[2];
    eps2 = eps * eps;
  end

  always_ff @(posedge clk) begin
    if (step[1]) begin
      short_p[0] <= (mzero[0] && mzero[1] && mzero[2]) ||
                    (len2 < {{(sbct_pkg::SQ_W-2*sbct_pkg::EPS_W){1'b0}}, eps2});
    end
  end

  for (genvar k = 1; k <= FRAC_BITS + 1; k++) begin : g_short
    always_ff @(posedge clk) if (step[k+1]) short_p[k] <= short_p[k-1];
  end

  // latest entry, earliest exit over bounded axes
  always_comb begin
    ent     = '1;
    ext     = T_ONE;
    any_sep = 1'b0;
    sep_nz  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (stat[i].sep) begin
        any_sep = 1'b1;
        if (stat[i].nz) sep_nz = 1'b1;
      end
      if (!stat[i].nz) begin
        if (slab_entry[i] > ent) ent = slab_entry[i];
        if (slab_exit[i] < ext)  ext = slab_exit[i];
      end
    end
    if (short_p[FRAC_BITS+1]) begin
      hit_w = !any_sep;
      t_w   = hit_w ? '0 : T_ONE[FRAC_BITS:0];
    end else begin
      hit_w = !sep_nz && (ent <= ext) && !ent[TW-1] && (ent < T_ONE);
      t_w   = hit_w ? ent[FRAC_BITS:0] : T_ONE[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+3]) begin
      hit_p[0] <= hit_w;
      t_p[0]   <= t_w;
    end
  end

  for (genvar k = 1; k <= 3; k++) begin : g_hit
    always_ff @(posedge clk) begin
      if (step[FRAC_BITS+3+k]) begin
        hit_p[k] <= hit_p[k-1];
        t_p[k]   <= t_p[k-1];
      end
    end
  end

  assign t_hit = t_p[0];

  // axis of smallest overlap, y first, then x
  always_comb begin
    if (ov[1] <= ov[0] && ov[1] <= ov[2]) ax = sbct_pkg::AXIS_Y;
    else if (ov[0] <= ov[2])              ax = sbct_pkg::AXIS_X;
    else                                  ax = sbct_pkg::AXIS_Z;
    unique case (ax)
      sbct_pkg::AXIS_X: neg_w = !above[0];
      sbct_pkg::AXIS_Y: neg_w = !above[1];
      sbct_pkg::AXIS_Z: neg_w = !above[2];
      default:          neg_w = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (step[FRAC_BITS+7]) begin
      hit        <= hit_p[3];
      hit_time   <= sbct_pkg::TIME_W'(t_p[3]);
      contact_x  <= csat[0];
      contact_y  <= csat[1];
      contact_z  <= csat[2];
      if (hit_p[3]) begin
        normal_axis     <= ax;
        normal_negative <= neg_w;
        if (ax == sbct_pkg::AXIS_Y)
          surface_kind <= neg_w ? sbct_pkg::SURF_CEILING : sbct_pkg::SURF_FLOOR;
        else
          surface_kind <= sbct_pkg::SURF_WALL;
      end else begin
        normal_axis     <= sbct_pkg::AXIS_Y;
        normal_negative <= 1'b0;
        surface_kind    <= sbct_pkg::SURF_FLOOR;
      end
    end
  end

endmodule

### hdl/swept_box_collision_time_unit.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time_unit: swept box against static box, slab method
// Three axis lanes with pipelined dividers and a merging result stage.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one swept test per beat (start centre, movement, static box).
//   result : one beat per test, in order: hit, entry time, normal, surface
//            kind and saturated contact centre.
//   cfg    : register writes (body sizes, motion epsilon), always ready;
//            write only while no test is in flight.
// Pipeline: the numerator and setup stages, the FRAC_BITS stages of the
//   restoring dividers in each lane, then the clamp, merge, multiply,
//   contact, overlap and output stages.
// Throughput: one test per cycle while result.ready holds; every stage
//   advances when it is empty or the stage after it moves.
// Reset: clears all stage valid bits and loads the register reset values.
// Stall: a waiting result holds in the output register; earlier stages keep
//   filling bubbles, and sample.ready drops only once the pipe is full.
// ----------------------------------------------------------------------------
module swept_box_collision_time_unit #(
  parameter int FRAC_BITS = sbct_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  sbct_in_if.sink     sample,
  sbct_out_if.source  result,
  sbct_cfg_if.sink    cfg
);

  localparam int NST = FRAC_BITS + 8;
  localparam int TW  = FRAC_BITS + 2;

  logic [NST-1:0] v;
  logic [NST-1:0] step;

  logic [sbct_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic [sbct_pkg::EPS_W-1:0]  eps;

  logic [sbct_pkg::SQ_W-1:0]           msq [3];
  logic                                mzero [3];
  sbct_pkg::lane_stat_t                stat [3];
  logic signed [TW-1:0]                slab_entry [3];
  logic signed [TW-1:0]                slab_exit [3];
  logic [FRAC_BITS:0]                  t_hit;
  logic signed [sbct_pkg::OV_W-1:0]    ov [3];
  logic                                above [3];
  logic signed [sbct_pkg::COORD_W-1:0] csat [3];

  // stage advance: empty or the next stage moves
  always_comb begin
    step[NST-1] = !v[NST-1] || result.ready;
    for (int k = NST - 2; k >= 0; k--) step[k] = !v[k] || step[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (step[0]) v[0] <= sample.valid;
      for (int k = 1; k < NST; k++) if (step[k]) v[k] <= v[k-1];
    end
  end

  assign sample.ready = step[0];
  assign result.valid = v[NST-1];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= sbct_pkg::SIZE_RESET;
      size_y <= sbct_pkg::SIZE_RESET;
      size_z <= sbct_pkg::SIZE_RESET;
      eps    <= sbct_pkg::EPS_RESET;
    end else if (cfg.valid) begin
      unique case (sbct_pkg::cfg_idx_t'(cfg.index))
        sbct_pkg::CFG_SIZE_X: size_x <= cfg.data[sbct_pkg::SIZE_W-1:0];
        sbct_pkg::CFG_SIZE_Y: size_y <= cfg.data[sbct_pkg::SIZE_W-1:0];
        sbct_pkg::CFG_SIZE_Z: size_z <= cfg.data[sbct_pkg::SIZE_W-1:0];
        sbct_pkg::CFG_EPS:    eps    <= cfg.data[sbct_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // axis lanes
  sbct_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .step(step), .s(sample.start_x), .m(sample.move_x),
    .bmin(sample.box_min_x), .bmax(sample.box_max_x), .sz(size_x), .eps(eps),
    .msq(msq[0]), .mzero(mzero[0]), .stat(stat[0]), .slab_entry(slab_entry[0]),
    .slab_exit(slab_exit[0]), .t_hit(t_hit), .ov(ov[0]), .above(above[0]),
    .csat(csat[0])
  );

  sbct_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .step(step), .s(sample.start_y), .m(sample.move_y),
    .bmin(sample.box_min_y), .bmax(sample.box_max_y), .sz(size_y), .eps(eps),
    .msq(msq[1]), .mzero(mzero[1]), .stat(stat[1]), .slab_entry(slab_entry[1]),
    .slab_exit(slab_exit[1]), .t_hit(t_hit), .ov(ov[1]), .above(above[1]),
    .csat(csat[1])
  );

  sbct_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .step(step), .s(sample.start_z), .m(sample.move_z),
    .bmin(sample.box_min_z), .bmax(sample.box_max_z), .sz(size_z), .eps(eps),
    .msq(msq[2]), .mzero(mzero[2]), .stat(stat[2]), .slab_entry(slab_entry[2]),
    .slab_exit(slab_exit[2]), .t_hit(t_hit), .ov(ov[2]), .above(above[2]),
    .csat(csat[2])
  );

  // merging stage and result register
  sbct_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .step(step), .eps(eps), .msq(msq), .mzero(mzero), .stat(stat),
    .slab_entry(slab_entry), .slab_exit(slab_exit), .t_hit(t_hit), .ov(ov),
    .above(above), .csat(csat), .hit(result.hit), .hit_time(result.hit_time),
    .normal_axis(result.normal_axis), .normal_negative(result.normal_negative),
    .surface_kind(result.surface_kind), .contact_x(result.contact_x),
    .contact_y(result.contact_y), .contact_z(result.contact_z)
  );

  // checks
  a_miss_default: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.hit |->
      result.normal_axis == sbct_pkg::AXIS_Y && !result.normal_negative &&
      result.surface_kind == sbct_pkg::SURF_FLOOR)
    else $error("miss without default normal");

  a_wall_axis: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |->
      ((result.surface_kind == sbct_pkg::SURF_WALL) ==
       (result.normal_axis != sbct_pkg::AXIS_Y)))
    else $error("surface kind does not follow normal axis");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NST-1] |-> sample.ready)
    else $error("input refused with empty output stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && sample.ready == step[0])
    else $error("result lost under stall");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the swept box collision time unit
// Drives swept box tests under random idling, predicts each result with an
// exact slab-method model and checks every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int FB = sbct_pkg::FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int LAT = FB + 8;

  typedef struct {
    logic signed [31:0] s[3];
    logic signed [31:0] m[3];
    logic signed [31:0] bmin[3];
    logic signed [31:0] bmax[3];
  } sweep_t;

  typedef struct {
    logic hit;
    logic [sbct_pkg::TIME_W-1:0] t;
    logic [1:0] axis;
    logic neg;
    logic [1:0] kind;
    logic signed [31:0] c[3];
  } contact_t;

  logic clk = 0;
  logic rst = 1;
  int errors = 0;
  bit idle_off = 0;

  sbct_in_if  sample();
  sbct_out_if result();
  sbct_cfg_if cfg();

  swept_box_collision_time_unit dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg)
  );

  // predictor copy of the registers
  longint size_reg[3];
  longint eps_reg;
  contact_t expected_q[$];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic longint fdiv(longint a, longint b);
    longint q, r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((r < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact slab-method collision prediction
  function automatic contact_t predict_contact(sweep_t x);
    contact_t r;
    longint s[3], m[3], lo[3], hi[3], mn[3], mx[3], c[3], ov[3];
    longint t, en, ex, t1, t2, a, b, am, entry, exitt;
    longint unsigned len2;
    bit all_zero, hit, over, sep;
    int ax;
    len2 = 0;
    all_zero = 1;
    hit = 0;
    t = ONE;
    for (int i = 0; i < 3; i++) begin
      s[i] = x.s[i]; m[i] = x.m[i]; mn[i] = x.bmin[i]; mx[i] = x.bmax[i];
      lo[i] = 2 * s[i] - size_reg[i];
      hi[i] = 2 * s[i] + size_reg[i];
      len2 += longint'(m[i] * m[i]);
      if (m[i] != 0) all_zero = 0;
    end
    if (all_zero || len2 < longint'(eps_reg * eps_reg)) begin
      over = 1;
      for (int i = 0; i < 3; i++)
        if (hi[i] < 2 * mn[i] || lo[i] > 2 * mx[i]) over = 0;
      if (over) begin hit = 1; t = 0; end
    end else begin
      entry = 64'h8000000000000000;
      exitt = 64'h7fffffffffffffff;
      sep = 0;
      for (int i = 0; i < 3; i++) begin
        am = m[i] < 0 ? -m[i] : m[i];
        if (m[i] == 0 || am < eps_reg) begin
          if (hi[i] < 2 * mn[i] || lo[i] > 2 * mx[i]) sep = 1;
        end else begin
          t1 = fdiv((2 * mn[i] - hi[i]) * ONE, 2 * m[i]);
          t2 = fdiv((2 * mx[i] - lo[i]) * ONE, 2 * m[i]);
          en = t1 < t2 ? t1 : t2;
          ex = t1 < t2 ? t2 : t1;
          if (en > entry) entry = en;
          if (ex < exitt) exitt = ex;
        end
      end
      if (!sep && entry <= exitt && entry >= 0 && entry < ONE) begin
        hit = 1; t = entry;
      end
    end
    for (int i = 0; i < 3; i++) c[i] = s[i] + fdiv(m[i] * t, ONE);
    r.axis = sbct_pkg::AXIS_Y; r.neg = 0; r.kind = sbct_pkg::SURF_FLOOR;
    if (hit) begin
      for (int i = 0; i < 3; i++) begin
        a = 2 * c[i] + size_reg[i] - 2 * mn[i];
        b = 2 * mx[i] - (2 * c[i] - size_reg[i]);
        ov[i] = a < b ? a : b;
      end
      if (ov[1] <= ov[0] && ov[1] <= ov[2]) ax = 1;
      else if (ov[0] <= ov[2]) ax = 0;
      else ax = 2;
      r.axis = ax[1:0];
      r.neg = (2 * c[ax] > mn[ax] + mx[ax]) ? 1'b0 : 1'b1;
      r.kind = (ax == 1) ? (r.neg ? sbct_pkg::SURF_CEILING : sbct_pkg::SURF_FLOOR)
                         : sbct_pkg::SURF_WALL;
    end
    r.hit = hit;
    r.t = t[sbct_pkg::TIME_W-1:0];
    for (int i = 0; i < 3; i++) r.c[i] = sat(c[i]);
    return r;
  endfunction

  function automatic bit idle_now();
    return !idle_off && ($urandom_range(99) < 33);
  endfunction

  // result side: random ready
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= !idle_now();
  end

  // result checker
  always @(posedge clk) begin
    contact_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, hit=%0b", $time, result.hit);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.hit !== e.hit || result.hit_time !== e.t ||
            result.normal_axis !== e.axis || result.normal_negative !== e.neg ||
            result.surface_kind !== e.kind || result.contact_x !== e.c[0] ||
            result.contact_y !== e.c[1] || result.contact_z !== e.c[2]) begin
          $display("%0t: mismatch expected hit=%0b t=%0d ax=%0d neg=%0b k=%0d c=%0d,%0d,%0d",
                   $time, e.hit, e.t, e.axis, e.neg, e.kind, e.c[0], e.c[1], e.c[2]);
          $display("%0t:          actual hit=%0b t=%0d ax=%0d neg=%0b k=%0d c=%0d,%0d,%0d",
                   $time, result.hit, result.hit_time, result.normal_axis,
                   result.normal_negative, result.surface_kind,
                   result.contact_x, result.contact_y, result.contact_z);
          errors++;
        end
      end
    end
  end

  // send one test beat, with a random gap ahead of it
  task automatic send_sweep(sweep_t x);
    while (idle_now()) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.start_x <= x.s[0];    sample.start_y <= x.s[1];    sample.start_z <= x.s[2];
    sample.move_x <= x.m[0];     sample.move_y <= x.m[1];     sample.move_z <= x.m[2];
    sample.box_min_x <= x.bmin[0]; sample.box_min_y <= x.bmin[1];
    sample.box_min_z <= x.bmin[2];
    sample.box_max_x <= x.bmax[0]; sample.box_max_y <= x.bmax[1];
    sample.box_max_z <= x.bmax[2];
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    expected_q.push_back(predict_contact(x));
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // one register write beat; the caller drops valid after the last one
  task automatic write_reg(sbct_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      sbct_pkg::CFG_SIZE_X: size_reg[0] = val[30:0];
      sbct_pkg::CFG_SIZE_Y: size_reg[1] = val[30:0];
      sbct_pkg::CFG_SIZE_Z: size_reg[2] = val[30:0];
      sbct_pkg::CFG_EPS:    eps_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] ep);
    drain();
    write_reg(sbct_pkg::CFG_SIZE_X, sx);
    write_reg(sbct_pkg::CFG_SIZE_Y, sy);
    write_reg(sbct_pkg::CFG_SIZE_Z, sz);
    write_reg(sbct_pkg::CFG_EPS, ep);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_coord(int range_sel);
    case (range_sel)
      0: return $urandom();
      1: return $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;
      default: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
    endcase
  endfunction

  // well-formed sweep aimed at a nearby box, or raw noise
  function automatic sweep_t rnd_sweep();
    sweep_t x;
    int mode;
    logic signed [31:0] h;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (mode == 0) begin
        x.s[i] = $urandom(); x.m[i] = $urandom();
        x.bmin[i] = $urandom(); x.bmax[i] = $urandom();
      end else begin
        x.bmin[i] = rnd_coord(1);
        h = $urandom_range(4 * 65536);
        x.bmax[i] = (mode == 1) ? x.bmin[i] - h : x.bmin[i] + h;
        x.s[i] = rnd_coord(mode < 5 ? 1 : 2);
        case ($urandom_range(5))
          0: x.m[i] = 0;
          1: x.m[i] = $signed($urandom_range(200)) - 100;
          default: x.m[i] = (x.bmin[i] - x.s[i]) +
                            $signed($urandom_range(4 * 65536)) - 2 * 65536;
        endcase
      end
    end
    return x;
  endfunction

  function automatic sweep_t mk(logic signed [31:0] s, logic signed [31:0] m,
                                logic signed [31:0] lo, logic signed [31:0] hi);
    sweep_t x;
    for (int i = 0; i < 3; i++) begin
      x.s[i] = s; x.m[i] = m; x.bmin[i] = lo; x.bmax[i] = hi;
    end
    return x;
  endfunction

  // directed: extremes, short movement, near-zero axes, entry at one, ties
  task automatic test_directed();
    sweep_t x;
    send_sweep(mk(0, 0, -65536, 65536));
    send_sweep(mk(0, 0, 5 * 65536, 6 * 65536));
    send_sweep(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send_sweep(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    send_sweep(mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send_sweep(mk(-1, -1, -1, -1));
    send_sweep(mk(0, 40, -65536, 65536));
    send_sweep(mk(0, 40, 3 * 65536, 4 * 65536));
    x = mk(0, 0, -65536, 65536);
    x.m[0] = 10 * 65536; x.bmin[0] = 4 * 65536; x.bmax[0] = 5 * 65536;
    send_sweep(x);
    x.m[0] = 3 * 65536 + 32768; x.bmin[0] = 4 * 65536;
    send_sweep(x);
    x.m[0] = -10 * 65536; x.bmin[0] = -5 * 65536; x.bmax[0] = -4 * 65536;
    send_sweep(x);
    x.bmin[1] = 5 * 65536; x.bmax[1] = 6 * 65536; x.m[1] = 10;
    send_sweep(x);
    x = mk(0, 65536, 65536, 2 * 65536);
    send_sweep(x);
    x = mk(0, 65536, -2 * 65536, 2 * 65536);
    send_sweep(x);
    x = mk(0, -65536, -3 * 65536, -65536 - 32768);
    send_sweep(x);
    x = mk(0, 65536, 65536 + 32768, 3 * 65536);
    x.m[1] = 0; x.bmin[1] = -65536; x.bmax[1] = 65536;
    send_sweep(x);
    x = mk(0, 32'sh7fffffff, 32'sh40000000, 32'sh7fffffff);
    send_sweep(x);
    x = mk(0, 32'sh80000000, 32'sh80000000, 32'shc0000000);
    send_sweep(x);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      idle_off = (k >= n / 3 && k < n / 3 + 120);
      send_sweep(rnd_sweep());
    end
    idle_off = 0;
  endtask

  // sender holds off until every result is back, then resumes
  task automatic test_hold_off();
    repeat (20) send_sweep(rnd_sweep());
    sample.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) send_sweep(rnd_sweep());
  endtask

  initial begin
    sample.valid = 0;
    sample.start_x = 0; sample.start_y = 0; sample.start_z = 0;
    sample.move_x = 0; sample.move_y = 0; sample.move_z = 0;
    sample.box_min_x = 0; sample.box_min_y = 0; sample.box_min_z = 0;
    sample.box_max_x = 0; sample.box_max_y = 0; sample.box_max_z = 0;
    cfg.valid = 0; cfg.index = sbct_pkg::CFG_SIZE_X; cfg.data = 0;
    for (int i = 0; i < 3; i++) size_reg[i] = sbct_pkg::SIZE_RESET;
    eps_reg = sbct_pkg::EPS_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(500);
    test_hold_off();
    set_config(0, 0, 0, 0);
    test_directed();
    test_random(200);
    set_config(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0000ffff);
    test_directed();
    test_random(200);
    set_config(3 * 65536, 65536 / 2, 2 * 65536, 1000);
    test_random(300);
    set_config($urandom(), $urandom(), $urandom(), $urandom());
    test_random(150);
    drain();

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

### swept_box_collision_time_unit.f
hdl/sbct_pkg.sv
hdl/sbct_if.sv
hdl/sbct_div_step.sv
hdl/sbct_lane.sv
hdl/sbct_merge.sv
hdl/swept_box_collision_time_unit.sv
tb/sv/tb_top.sv
